// ----- sv/chs_pkg.sv -----
// shared constants, types and hash function of the chained hash symbol table
package chs_pkg;

    localparam int BUCKETS     = 513;
    localparam int MAX_ENTRIES = 1024;
    localparam int NAME_BYTES  = 64;

    localparam int HASH_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int SLOT_W   = $clog2(MAX_ENTRIES);
    localparam int USED_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W    = $clog2(NAME_BYTES);
    localparam int LEN_W    = $clog2(NAME_BYTES + 1);
    localparam int MOD_STEPS = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] key_type;
        logic [DATA_W-1:0] value;
        logic [SLOT_W-1:0] link;
    } t_meta;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } t_mod_rsp;

    function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] h_in,
                                                   input logic [CHAR_W-1:0] c);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] top;
        h   = (h_in << 4) + {{(HASH_W-CHAR_W){1'b0}}, c};
        top = h & 32'hF000_0000;
        if (top != '0) begin
            h = h ^ (top >> 24);
        end
        return h & ~top;
    endfunction

endpackage

// ----- sv/chs_if.sv -----
// handshake channels for request characters and results
interface chs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [chs_pkg::CHAR_W-1:0]          key_char;
    logic                                key_last;
    logic [chs_pkg::DATA_W-1:0]          key_type;
    logic [chs_pkg::DATA_W-1:0]          entry_value;
    modport source (output valid, func, key_char, key_last, key_type, entry_value,
                    input ready);
    modport sink (input valid, func, key_char, key_last, key_type, entry_value,
                  output ready);
endinterface

interface chs_out_if;
    logic                           valid;
    logic                           ready;
    logic [chs_pkg::STATUS_W-1:0]   status;
    logic [chs_pkg::DATA_W-1:0]     found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink (input valid, status, found_value, output ready);
endinterface

// ----- sv/chs_ram.sv -----
// generic single-port ram with registered read
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/chs_mod.sv -----
// iterative hash modulo bucket count, MOD_STEPS hash bits per cycle
module chs_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [chs_pkg::HASH_W-1:0]  i_hash,
    output chs_pkg::t_mod_rsp           o_rsp
);
    localparam int CNT = chs_pkg::HASH_W / chs_pkg::MOD_STEPS;
    localparam int CNT_W = $clog2(CNT);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [chs_pkg::HASH_W-1:0]  r_word, n_word;
    logic [chs_pkg::BKT_W-1:0]   r_rem, n_rem;

    always_comb begin
        logic [chs_pkg::BKT_W:0] rem;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_rem  = r_rem;
        rem    = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_word = i_hash;
            n_rem  = '0;
        end else if (r_busy) begin
            rem = {1'b0, r_rem};
            for (int k = 0; k < chs_pkg::MOD_STEPS; k++) begin
                rem = {rem[chs_pkg::BKT_W-1:0], r_word[chs_pkg::HASH_W-1-k]};
                if (rem >= (chs_pkg::BKT_W+1)'(chs_pkg::BUCKETS)) begin
                    rem = rem - (chs_pkg::BKT_W+1)'(chs_pkg::BUCKETS);
                end
            end
            n_rem  = rem[chs_pkg::BKT_W-1:0];
            n_word = r_word << chs_pkg::MOD_STEPS;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(CNT - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.bucket = r_rem;
endmodule

// ----- sv/chained_hash_symbol_table.sv -----
// chained hash symbol table: top level with chain walker and memories
//
// the request channel takes a name one character per transfer; key_last
// marks the final character, and only then are func, key_type and
// entry_value used. ordinary characters are taken one per cycle. the final
// character starts the operation and the request channel stays stalled until
// its single result has been transferred on the result channel.
// operation: after the final transfer the block waits on the modulo unit and
// reads the bucket head; each chain entry then takes a metadata read, plus a
// read and compare per name byte when length and type agree, and a decide
// step ends the walk; an insert then copies the name byte by byte and links.
// the walk is set by the single-port entry memories, one access a cycle.
// an over-long name is reported straight away, without a walk.
// after reset the bucket head memory is cleared, one bucket a cycle, for all
// 513 buckets, before the first character is taken.
// when the receiver stalls the result register holds its value and no new
// character is taken.
module chained_hash_symbol_table (
    input  logic     i_clk,
    input  logic     i_rst_n,
    chs_in_if.sink   i_in,
    chs_out_if.source o_out
);
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_CLR   = 4'd0;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
    localparam logic [ST_W-1:0] S_MOD   = 4'd2;
    localparam logic [ST_W-1:0] S_HEAD  = 4'd3;
    localparam logic [ST_W-1:0] S_HEADW = 4'd4;
    localparam logic [ST_W-1:0] S_WALK  = 4'd5;
    localparam logic [ST_W-1:0] S_METAW = 4'd6;
    localparam logic [ST_W-1:0] S_CMPRD = 4'd7;
    localparam logic [ST_W-1:0] S_CMPW  = 4'd8;
    localparam logic [ST_W-1:0] S_DECIDE = 4'd9;
    localparam logic [ST_W-1:0] S_CPYRD = 4'd10;
    localparam logic [ST_W-1:0] S_CPYW  = 4'd11;
    localparam logic [ST_W-1:0] S_NEWMETA = 4'd12;
    localparam logic [ST_W-1:0] S_LINK  = 4'd13;
    localparam logic [ST_W-1:0] S_OUT   = 4'd14;

    localparam int META_W = $bits(chs_pkg::t_meta);
    localparam int NAME_AW = chs_pkg::SLOT_W + chs_pkg::IDX_W;

    logic [ST_W-1:0]                r_state, n_state;
    logic [chs_pkg::HASH_W-1:0]     r_hash, n_hash;
    logic [chs_pkg::LEN_W-1:0]      r_len, n_len;
    logic [chs_pkg::USED_W-1:0]     r_used, n_used;
    logic [chs_pkg::BKT_W-1:0]      r_clr, n_clr;
    logic [chs_pkg::BKT_W-1:0]      r_bucket, n_bucket;
    logic [chs_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [chs_pkg::SLOT_W-1:0]     r_tail, n_tail;
    logic [chs_pkg::LEN_W-1:0]      r_idx, n_idx;
    logic                           r_hit, n_hit;
    logic                           r_func, n_func;
    logic [chs_pkg::DATA_W-1:0]     r_type, n_type;
    logic [chs_pkg::DATA_W-1:0]     r_value, n_value;
    chs_pkg::t_meta                 r_meta, n_meta;
    logic [chs_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [chs_pkg::DATA_W-1:0]     r_found, n_found;

    logic                           mod_start;
    chs_pkg::t_mod_rsp              mod_rsp;
    logic [chs_pkg::HASH_W-1:0]     hash_next;
    logic [chs_pkg::LEN_W-1:0]      len_next;

    logic                           kb_we;
    logic [chs_pkg::IDX_W-1:0]      kb_addr;
    logic [chs_pkg::CHAR_W-1:0]     kb_rdata;
    logic                           hd_we;
    logic [chs_pkg::BKT_W-1:0]      hd_addr;
    logic [chs_pkg::SLOT_W-1:0]     hd_wdata, hd_rdata;
    logic                           nm_we;
    logic [NAME_AW-1:0]             nm_addr;
    logic [chs_pkg::CHAR_W-1:0]     nm_rdata;
    logic                           mt_we;
    logic [chs_pkg::SLOT_W-1:0]     mt_addr;
    chs_pkg::t_meta                 mt_wdata, mt_rdata;
    logic [chs_pkg::SLOT_W-1:0]     fresh;

    assign fresh = r_used[chs_pkg::SLOT_W-1:0];
    assign hash_next = chs_pkg::elf_fold(r_hash, i_in.key_char);
    assign len_next = (r_len < chs_pkg::LEN_W'(chs_pkg::NAME_BYTES - 1))
                    ? r_len + 1'b1 : chs_pkg::LEN_W'(chs_pkg::NAME_BYTES);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.status = r_status;
    assign o_out.found_value = r_found;

    always_comb begin
        n_state  = r_state;
        n_hash   = r_hash;
        n_len    = r_len;
        n_used   = r_used;
        n_clr    = r_clr;
        n_bucket = r_bucket;
        n_slot   = r_slot;
        n_tail   = r_tail;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_func   = r_func;
        n_type   = r_type;
        n_value  = r_value;
        n_meta   = r_meta;
        n_status = r_status;
        n_found  = r_found;
        mod_start = 1'b0;
        kb_we    = 1'b0;
        kb_addr  = r_idx[chs_pkg::IDX_W-1:0];
        hd_we    = 1'b0;
        hd_addr  = r_bucket;
        hd_wdata = fresh;
        nm_we    = 1'b0;
        nm_addr  = {r_slot, r_idx[chs_pkg::IDX_W-1:0]};
        mt_we    = 1'b0;
        mt_addr  = r_slot;
        mt_wdata = r_meta;
        unique case (r_state)
            S_CLR: begin
                hd_we    = 1'b1;
                hd_addr  = r_clr;
                hd_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == chs_pkg::BKT_W'(chs_pkg::BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                kb_addr = r_len[chs_pkg::IDX_W-1:0];
                if (i_in.valid) begin
                    kb_we   = (r_len < chs_pkg::LEN_W'(chs_pkg::NAME_BYTES - 1));
                    n_hash  = hash_next;
                    n_len   = len_next;
                    n_func  = i_in.func;
                    n_type  = i_in.key_type;
                    n_value = i_in.entry_value;
                    n_found = '0;
                    n_hit   = 1'b0;
                    if (i_in.key_last) begin
                        if (len_next >= chs_pkg::LEN_W'(chs_pkg::NAME_BYTES)) begin
                            n_status = chs_pkg::ST_TOO_LONG;
                            n_state  = S_OUT;
                        end else begin
                            mod_start = 1'b1;
                            n_state   = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_bucket = mod_rsp.bucket;
                    n_state  = S_HEAD;
                end
            end
            S_HEAD: n_state = S_HEADW;
            S_HEADW: begin
                n_slot  = hd_rdata;
                n_tail  = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_slot == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_METAW;
                end
            end
            S_METAW: begin
                n_meta = mt_rdata;
                n_idx  = '0;
                if (mt_rdata.len == r_len && mt_rdata.key_type == r_type) begin
                    n_state = S_CMPRD;
                end else begin
                    n_tail  = r_slot;
                    n_slot  = mt_rdata.link;
                    n_state = S_WALK;
                end
            end
            S_CMPRD: n_state = S_CMPW;
            S_CMPW: begin
                if (kb_rdata != nm_rdata) begin
                    n_tail  = r_slot;
                    n_slot  = r_meta.link;
                    n_state = S_WALK;
                end else if (r_idx + 1'b1 == r_len) begin
                    n_hit   = 1'b1;
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CMPRD;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                n_state = S_OUT;
                if (r_func == chs_pkg::FUNC_LOOKUP) begin
                    n_status = r_hit ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
                    n_found  = r_hit ? r_meta.value : '0;
                end else if (r_hit) begin
                    n_status = chs_pkg::ST_DUPLICATE;
                end else if (r_used >= chs_pkg::USED_W'(chs_pkg::MAX_ENTRIES)) begin
                    n_status = chs_pkg::ST_FULL;
                end else begin
                    n_state = S_CPYRD;
                end
            end
            S_CPYRD: n_state = S_CPYW;
            S_CPYW: begin
                nm_we   = 1'b1;
                nm_addr = {fresh, r_idx[chs_pkg::IDX_W-1:0]};
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx + 1'b1 == r_len) ? S_NEWMETA : S_CPYRD;
            end
            S_NEWMETA: begin
                mt_we             = 1'b1;
                mt_addr           = fresh;
                mt_wdata.len      = r_len;
                mt_wdata.key_type = r_type;
                mt_wdata.value    = r_value;
                mt_wdata.link     = '0;
                n_state           = S_LINK;
            end
            S_LINK: begin
                // r_meta still holds the tail entry read during the walk
                if (r_tail == '0) begin
                    hd_we = 1'b1;
                end else begin
                    mt_we         = 1'b1;
                    mt_addr       = r_tail;
                    mt_wdata.link = fresh;
                end
                n_used   = r_used + 1'b1;
                n_status = chs_pkg::ST_STORED;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_hash  = '0;
                    n_len   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_hash  <= '0;
            r_len   <= '0;
            r_used  <= chs_pkg::USED_W'(1);
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_len   <= n_len;
            r_used  <= n_used;
            r_clr   <= n_clr;
        end
        r_bucket <= n_bucket;
        r_slot   <= n_slot;
        r_tail   <= n_tail;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_func   <= n_func;
        r_type   <= n_type;
        r_value  <= n_value;
        r_meta   <= n_meta;
        r_status <= n_status;
        r_found  <= n_found;
    end

    chs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_hash  (hash_next),
        .o_rsp   (mod_rsp)
    );

    chs_ram #(.WIDTH(chs_pkg::CHAR_W), .DEPTH(chs_pkg::NAME_BYTES)) u_key_buf (
        .i_clk(i_clk), .i_we(kb_we), .i_addr(kb_addr),
        .i_wdata(i_in.key_char), .o_rdata(kb_rdata)
    );

    chs_ram #(.WIDTH(chs_pkg::SLOT_W), .DEPTH(chs_pkg::BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_addr(hd_addr),
        .i_wdata(hd_wdata), .o_rdata(hd_rdata)
    );

    chs_ram #(.WIDTH(chs_pkg::CHAR_W),
              .DEPTH(chs_pkg::MAX_ENTRIES * chs_pkg::NAME_BYTES)) u_names (
        .i_clk(i_clk), .i_we(nm_we), .i_addr(nm_addr),
        .i_wdata(kb_rdata), .o_rdata(nm_rdata)
    );

    chs_ram #(.WIDTH(META_W), .DEPTH(chs_pkg::MAX_ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(mt_we), .i_addr(mt_addr),
        .i_wdata(mt_wdata), .o_rdata(mt_rdata)
    );
endmodule

// ----- sv/chs_checker.sv -----
// port-level checks of the symbol table, bound to the top level
module chs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [chs_pkg::STATUS_W-1:0]  i_status,
    input logic [chs_pkg::DATA_W-1:0]    i_found_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_found_value))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= chs_pkg::ST_TOO_LONG)
        else $error("status code out of range");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found_value != '0 |-> i_status == chs_pkg::ST_FOUND)
        else $error("value shown without a hit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("character taken while a result is pending");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid && !i_in_ready)
        else $error("activity straight after reset");
endmodule

bind chained_hash_symbol_table chs_checker u_chs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_found_value (o_out.found_value)
);
